### src/nllc_pkg.sv
// ----------------------------------------------------------------------------
// nllc_pkg: shared definitions for the newline index and line/column lookup
// Sizes, character codes, operation codes, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package nllc_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int MAX_BREAKS  = 4096;
  localparam int IDX_BITS    = $clog2(MAX_BREAKS);
  localparam int COUNT_BITS  = $clog2(MAX_BREAKS + 1);
  localparam int ENTRY_BITS  = OFFSET_BITS + 1;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int QUERY_W  = 24;
  localparam int LINE_W   = 13;
  localparam int COLUMN_W = 25;

  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_END   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CHECK = 2'd1,
    ST_CMP   = 2'd2,
    ST_FIN   = 2'd3
  } state_e;

  typedef struct packed {
    logic ingest;
    logic start_search;
    logic rd_mid;
    logic step_cmp;
    logic rd_prev;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic lo_zero;
    logic out_free;
  } dp_status_t;

endpackage

### src/nllc_ctrl.sv
// ----------------------------------------------------------------------------
// nllc_ctrl: sequencing of item intake and the binary search
// Takes items while idle, then steps the search one probe at a time.
// ----------------------------------------------------------------------------
module nllc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [nllc_pkg::OP_W-1:0] operation_i,
  input  nllc_pkg::dp_status_t    status_i,
  output nllc_pkg::ctrl_cmd_t     cmd_o,
  output logic                    in_stall_o
);
  import nllc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_e'(operation_i) == OP_QUERY) begin
            cmd_o.start_search = 1'b1;
            state_d            = ST_CHECK;
          end else begin
            cmd_o.ingest = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (status_i.lo_lt_hi) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = ST_CMP;
        end else begin
          // The entry just before the found break gives the line start.
          cmd_o.rd_prev = !status_i.lo_zero;
          state_d       = ST_FIN;
        end
      end
      ST_CMP: begin
        cmd_o.step_cmp = 1'b1;
        state_d        = ST_CHECK;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/nllc_datapath.sv
// ----------------------------------------------------------------------------
// nllc_datapath: break table, counters, search registers and result register
// The table is one memory of position and length; the search reads it at
// the probe index and compares against the query offset.
// ----------------------------------------------------------------------------
module nllc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nllc_pkg::ctrl_cmd_t           cmd_i,
  output nllc_pkg::dp_status_t          status_o,
  input  logic [nllc_pkg::OP_W-1:0]     operation_i,
  input  logic [nllc_pkg::BYTE_W-1:0]   byte_value_i,
  input  logic [nllc_pkg::QUERY_W-1:0]  query_offset_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [nllc_pkg::LINE_W-1:0]   line_number_o,
  output logic [nllc_pkg::COLUMN_W-1:0] column_number_o,
  output logic                          result_status_o
);
  import nllc_pkg::*;

  // Break table: bit OFFSET_BITS set means a two-byte CR LF break.
  logic [ENTRY_BITS-1:0] mem [MAX_BREAKS];
  logic [ENTRY_BITS-1:0] rdata_q;

  logic [COUNT_BITS-1:0]  count_q, count_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic                   pend_q, pend_d;
  logic [OFFSET_BITS-1:0] pend_off_q, pend_off_d;
  logic                   ovf_q, ovf_d;

  logic [COUNT_BITS-1:0]  lo_q, hi_q;
  logic [OFFSET_BITS-1:0] qoff_q;

  logic                   out_valid_q;
  logic [LINE_W-1:0]      line_q;
  logic [COLUMN_W-1:0]    col_q;
  logic                   stat_q;

  logic                   rec_en;
  logic [OFFSET_BITS-1:0] rec_pos;
  logic                   rec_two;
  logic                   full;
  logic                   wr_en;
  logic [OFFSET_BITS-1:0] offset_inc;

  logic [COUNT_BITS-1:0]  mid;
  logic [COUNT_BITS-1:0]  prev;
  logic                   rd_en;
  logic [IDX_BITS-1:0]    rd_addr;
  logic                   probe_ge;
  logic [COLUMN_W-1:0]    line_start;
  logic [COLUMN_W-1:0]    column;

  assign full       = (count_q == COUNT_BITS'(MAX_BREAKS));
  assign wr_en      = rec_en && !full;
  assign offset_inc = offset_q + OFFSET_BITS'(1);

  always_comb begin
    rec_en     = 1'b0;
    rec_pos    = offset_q;
    rec_two    = 1'b0;
    pend_d     = pend_q;
    pend_off_d = pend_off_q;
    count_d    = count_q;
    offset_d   = offset_q;
    ovf_d      = ovf_q;
    if (cmd_i.ingest) begin
      unique case (op_e'(operation_i))
        OP_BYTE: begin
          offset_d = offset_inc;
          if (offset_inc == '0) begin
            ovf_d = 1'b1;
          end
          if (pend_q) begin
            pend_d  = 1'b0;
            rec_en  = 1'b1;
            rec_pos = pend_off_q;
            rec_two = (byte_value_i == CHAR_LF);
            if (byte_value_i == CHAR_CR) begin
              pend_d     = 1'b1;
              pend_off_d = offset_q;
            end
          end else if (byte_value_i == CHAR_LF) begin
            rec_en = 1'b1;
          end else if (byte_value_i == CHAR_CR) begin
            pend_d     = 1'b1;
            pend_off_d = offset_q;
          end
        end
        OP_END: begin
          if (pend_q) begin
            pend_d  = 1'b0;
            rec_en  = 1'b1;
            rec_pos = pend_off_q;
          end
        end
        OP_CLEAR: begin
          pend_d     = 1'b0;
          pend_off_d = '0;
          offset_d   = '0;
        end
        OP_QUERY: begin
        end
        default: begin
        end
      endcase
      if (rec_en) begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          count_d = count_q + COUNT_BITS'(1);
        end
      end
      if (op_e'(operation_i) == OP_CLEAR) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  // Search probe and predecessor index.
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign prev     = lo_q - COUNT_BITS'(1);
  assign rd_en    = cmd_i.rd_mid || cmd_i.rd_prev;
  assign rd_addr  = cmd_i.rd_prev ? prev[IDX_BITS-1:0] : mid[IDX_BITS-1:0];
  assign probe_ge = (rdata_q[OFFSET_BITS-1:0] >= qoff_q);

  assign line_start = (lo_q == '0) ? '0 :
                      COLUMN_W'(rdata_q[OFFSET_BITS-1:0]) +
                      (rdata_q[OFFSET_BITS] ? COLUMN_W'(2) : COLUMN_W'(1));
  assign column     = COLUMN_W'(qoff_q) - line_start + COLUMN_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[IDX_BITS-1:0]] <= {rec_two, rec_pos};
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      offset_q    <= '0;
      pend_q      <= 1'b0;
      pend_off_q  <= '0;
      ovf_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      offset_q   <= offset_d;
      pend_q     <= pend_d;
      pend_off_q <= pend_off_d;
      ovf_q      <= ovf_d;
      if (cmd_i.start_search) begin
        lo_q <= '0;
        hi_q <= count_q;
      end else if (cmd_i.step_cmp) begin
        if (probe_ge) begin
          hi_q <= mid;
        end else begin
          lo_q <= mid + COUNT_BITS'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_search) begin
      qoff_q <= query_offset_i[OFFSET_BITS-1:0];
    end
    if (cmd_i.load_out) begin
      line_q <= LINE_W'(lo_q) + LINE_W'(1);
      col_q  <= column;
      stat_q <= ovf_q;
    end
  end

  assign status_o.lo_lt_hi = (lo_q < hi_q);
  assign status_o.lo_zero  = (lo_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign line_number_o   = line_q;
  assign column_number_o = col_q;
  assign result_status_o = stat_q;

endmodule

### src/newline_index_line_column_lookup.sv
// ----------------------------------------------------------------------------
// newline_index_line_column_lookup: line break index with line/column lookup
// Source bytes, end of source and clear are accepted back to back while no
// query is in progress. A query runs S = ceil(log2(count + 1)) probes, up to
// 13, each a pass through the registered table read.
// Reset (asynchronous, active low) clears counters, flags and handshakes; the
// table contents are not cleared, as entries past the count are never read.
// ----------------------------------------------------------------------------
module newline_index_line_column_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [nllc_pkg::OP_W-1:0]     operation_i,
  input  logic [nllc_pkg::BYTE_W-1:0]   byte_value_i,
  input  logic [nllc_pkg::QUERY_W-1:0]  query_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [nllc_pkg::LINE_W-1:0]   line_number_o,
  output logic [nllc_pkg::COLUMN_W-1:0] column_number_o,
  output logic                          status_o
);
  import nllc_pkg::*;

  // The controller only sequences; every stored value lives in the datapath.
  // Items are taken while the controller is idle. A query holds the input
  // side until its result has been loaded into the output register, which
  // then waits for the consumer while further source items flow in.
  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  nllc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .status_i    (dp_status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  // The datapath records each break as it is settled: an LF at once, a CR
  // when the next byte or the end-of-source item shows whether an LF joins
  // it. The search finds the first break at or after the query offset, then
  // reads its predecessor to work out where the line starts.
  nllc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .operation_i     (operation_i),
    .byte_value_i    (byte_value_i),
    .query_offset_i  (query_offset_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .line_number_o   (line_number_o),
    .column_number_o (column_number_o),
    .result_status_o (status_o)
  );

endmodule

### test/line_lookup_checker.sv
// ----------------------------------------------------------------------------
// line_lookup_checker: watches both channels of the line/column lookup
// Keeps its own copy of the break table and counters, works out the location
// that each accepted query must return, and compares every returned item with
// the oldest location still due. Failures are counted and handed upwards.
// ----------------------------------------------------------------------------
module line_lookup_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [nllc_pkg::OP_W-1:0]     operation_i,
  input  logic [nllc_pkg::BYTE_W-1:0]   byte_value_i,
  input  logic [nllc_pkg::QUERY_W-1:0]  query_offset_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [nllc_pkg::LINE_W-1:0]   line_number_i,
  input  logic [nllc_pkg::COLUMN_W-1:0] column_number_i,
  input  logic                          status_i,
  output int                            fail_count_o,
  output int                            due_count_o
);
  import nllc_pkg::*;

  typedef struct packed {
    logic [LINE_W-1:0]   line;
    logic [COLUMN_W-1:0] column;
    logic                status;
  } location_t;

  location_t locations_due [$];

  // Own copy of the block's state.
  logic [OFFSET_BITS-1:0] brk_pos [MAX_BREAKS];
  logic                   brk_two [MAX_BREAKS];
  int unsigned            brk_count;
  logic [OFFSET_BITS-1:0] src_offset;
  logic [OFFSET_BITS-1:0] cr_offset;
  logic                   cr_held;
  logic                   table_lost;

  function automatic void store_break(input logic [OFFSET_BITS-1:0] pos, input logic two);
    if (brk_count >= MAX_BREAKS) begin
      table_lost = 1'b1;
    end else begin
      brk_pos[brk_count] = pos;
      brk_two[brk_count] = two;
      brk_count++;
    end
  endfunction

  // Applies one accepted item to the state; a query adds the location it must
  // produce to the list of locations due.
  function automatic void index_source_item(input op_e op, input logic [BYTE_W-1:0] ch,
                                            input logic [QUERY_W-1:0] off);
    int unsigned         lo;
    int unsigned         hi;
    int unsigned         mid;
    logic                lf_taken;
    logic [COLUMN_W-1:0] line_start;
    location_t           loc;
    case (op)
      OP_BYTE: begin
        lf_taken = 1'b0;
        if (cr_held) begin
          cr_held = 1'b0;
          if (ch == CHAR_LF) begin
            store_break(cr_offset, 1'b1);
            lf_taken = 1'b1;
          end else begin
            store_break(cr_offset, 1'b0);
          end
        end
        if (!lf_taken) begin
          if (ch == CHAR_LF) begin
            store_break(src_offset, 1'b0);
          end else if (ch == CHAR_CR) begin
            cr_held   = 1'b1;
            cr_offset = src_offset;
          end
        end
        src_offset = src_offset + 1'b1;
        if (src_offset == '0) table_lost = 1'b1;
      end
      OP_END: begin
        if (cr_held) begin
          cr_held = 1'b0;
          store_break(cr_offset, 1'b0);
        end
      end
      OP_CLEAR: begin
        brk_count  = 0;
        src_offset = '0;
        cr_held    = 1'b0;
        cr_offset  = '0;
        table_lost = 1'b0;
      end
      default: begin
        // Lower bound search for the first break at or after the offset.
        lo = 0;
        hi = brk_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (brk_pos[mid] >= off) hi = mid;
          else lo = mid + 1;
        end
        if (lo == 0) begin
          loc.line   = LINE_W'(1);
          line_start = '0;
        end else begin
          loc.line   = LINE_W'(lo + 1);
          line_start = {1'b0, brk_pos[lo-1]} + (brk_two[lo-1] ? COLUMN_W'(2) : COLUMN_W'(1));
        end
        loc.column = {1'b0, off} - line_start + COLUMN_W'(1);
        loc.status = table_lost;
        locations_due.push_back(loc);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    location_t want;
    if (!rst_ni) begin
      brk_count  = 0;
      src_offset = '0;
      cr_held    = 1'b0;
      cr_offset  = '0;
      table_lost = 1'b0;
      locations_due.delete();
      fail_count_o = 0;
      due_count_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (locations_due.size() == 0) begin
          $display("%0t: location returned with none due (line %0d column %0d status %0d)",
                   $time, line_number_i, column_number_i, status_i);
          fail_count_o++;
        end else begin
          want = locations_due.pop_front();
          if (line_number_i !== want.line) begin
            $display("%0t: line expected %0d, got %0d", $time, want.line, line_number_i);
            fail_count_o++;
          end
          if (column_number_i !== want.column) begin
            $display("%0t: column expected %0d, got %0d", $time, want.column,
                     column_number_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        index_source_item(op_e'(operation_i), byte_value_i, query_offset_i);
      end
      due_count_o = locations_due.size();
    end
  end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the newline index with line/column lookup
// A short directed run covers the empty table, every kind of line break, a
// pending CR, queries before, on and after the breaks and the clear item.
// Random source text with queries follows, then a dense run in which nearly
// every byte is a line break. Both channels idle at random; a checker beside
// the block predicts every location and compares it.
// ----------------------------------------------------------------------------
module tb;
  import nllc_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  // Items of the dense run, nearly all of them line-break bytes, so the searches run deep.
  localparam int FILL_ITEMS   = 420;
  // Output hold-off long enough that a result waits and the block stalls its
  // input while items keep being offered.
  localparam int LONG_HOLD    = 400;
  // Drain time that covers the longest query with room to spare.
  localparam int DRAIN_CYCLES = 64;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     operation;
  logic [BYTE_W-1:0]   byte_value;
  logic [QUERY_W-1:0]  query_offset;
  logic                out_valid;
  logic                out_stall;
  logic [LINE_W-1:0]   line_number;
  logic [COLUMN_W-1:0] column_number;
  logic                status;

  int                  fail_count;
  int                  due_count;

  // Stimulus bookkeeping: bytes sent since the last clear, used to aim
  // queries at offsets that the table actually covers.
  int                  src_len;
  // While set, the sender offers items back to back.
  bit                  calm_send;
  logic                hold_off_req;

  newline_index_line_column_lookup uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .byte_value_i    (byte_value),
    .query_offset_i  (query_offset),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .line_number_o   (line_number),
    .column_number_o (column_number),
    .status_o        (status)
  );

  line_lookup_checker lookup_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .operation_i     (operation),
    .byte_value_i    (byte_value),
    .query_offset_i  (query_offset),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .line_number_i   (line_number),
    .column_number_i (column_number),
    .status_i        (status),
    .fail_count_o    (fail_count),
    .due_count_o     (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap before the next item: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // Offers one item and returns at the clock edge that accepts it. The stall
  // is sampled on the falling edge, where it is settled, so the acceptance
  // does not hinge on the order of events at the rising edge.
  task automatic offer(input op_e op, input logic [BYTE_W-1:0] ch,
                       input logic [QUERY_W-1:0] off);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    byte_value   <= ch;
    query_offset <= off;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (op == OP_BYTE) src_len++;
    if (op == OP_CLEAR) src_len = 0;
  endtask

  // Source byte; the unused offset field carries noise.
  task automatic put_byte(input logic [BYTE_W-1:0] ch);
    offer(OP_BYTE, ch, QUERY_W'($urandom));
  endtask

  // Location query; the unused byte field carries noise.
  task automatic ask(input logic [QUERY_W-1:0] off);
    offer(OP_QUERY, BYTE_W'($urandom), off);
  endtask

  // Random query offset, mostly inside or just past the text seen so far.
  function automatic logic [QUERY_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return QUERY_W'($urandom);
    if (r < 18) return QUERY_W'(src_len);
    return QUERY_W'($urandom_range(0, src_len + 2));
  endfunction

  // Random source byte with plenty of line breaks among ordinary text.
  function automatic logic [BYTE_W-1:0] pick_byte(input int lf_pct, input int cr_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < lf_pct) return CHAR_LF;
    if (r < lf_pct + cr_pct) return CHAR_CR;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Receiver: random stall pattern with quiet stretches, and once, when the
  // sender asks for it, a long hold-off so that the block backs up and stalls
  // its input while items keep being offered.
  initial begin
    int  r;
    bit  hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_off_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (r < 10) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else if (r < 13) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 30)) @(posedge clk);
      end else begin
        out_stall <= (r < 40);
        @(posedge clk);
      end
    end
  end

  // Main stimulus and verdict.
  initial begin
    int r;
    src_len      = 0;
    calm_send    = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    operation    <= OP_BYTE;
    byte_value   <= '0;
    query_offset <= '0;
    hold_off_req <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Queries on the empty table, at the lowest and the
    // highest offset, answer line 1.
    ask('0);
    ask('1);
    // Text "a LF CR LF CR CR b CR" with the last CR settled by end of source:
    // breaks at 1 (LF), 2 (CR LF), 4 (lone CR), 5 (CR before a letter) and
    // 7 (CR closed by end of source).
    put_byte(8'h61);
    put_byte(CHAR_LF);
    put_byte(CHAR_CR);
    // The CR at offset 2 is still pending here and must not be counted.
    ask(QUERY_W'(5));
    put_byte(CHAR_LF);
    put_byte(CHAR_CR);
    put_byte(CHAR_CR);
    put_byte(8'h62);
    put_byte(CHAR_CR);
    offer(OP_END, BYTE_W'($urandom), QUERY_W'($urandom));
    put_byte(8'hFF);
    put_byte(8'h00);
    // Before the first break, on it, on the LF of a CR LF pair (column 0),
    // after the last break, and the highest offset after the last break.
    ask(QUERY_W'(0));
    ask(QUERY_W'(1));
    ask(QUERY_W'(3));
    ask(QUERY_W'(9));
    ask('1);
    // Clear empties the table; end of source with nothing pending is a no-op.
    offer(OP_CLEAR, BYTE_W'($urandom), QUERY_W'($urandom));
    ask(QUERY_W'(2));
    offer(OP_END, BYTE_W'($urandom), QUERY_W'($urandom));

    // Random part: text with breaks, queries, end of source and the odd
    // clear. The long output hold-off falls near its start.
    hold_off_req <= 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) calm_send = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 999);
      if (r < 10) offer(OP_CLEAR, BYTE_W'($urandom), QUERY_W'($urandom));
      else if (r < 40) offer(OP_END, BYTE_W'($urandom), QUERY_W'($urandom));
      else if (r < 150) ask(pick_offset());
      else put_byte(pick_byte(12, 10));
    end

    // Dense part: nearly every byte is a line break, so the table holds
    // many short lines and the searches take their longer paths.
    offer(OP_CLEAR, BYTE_W'($urandom), QUERY_W'($urandom));
    for (int n = 0; n < FILL_ITEMS; n++) begin
      if (n % 64 == 0) calm_send = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 2) ask(pick_offset());
      else put_byte(pick_byte(85, 8));
    end
    offer(OP_END, BYTE_W'($urandom), QUERY_W'($urandom));
    ask('0);
    ask(QUERY_W'(src_len / 2));
    ask(QUERY_W'(src_len + 5));
    ask('1);
    // A clear empties the table again.
    offer(OP_CLEAR, BYTE_W'($urandom), QUERY_W'($urandom));
    ask('0);
    in_valid <= 1'b0;

    // Table overflow and offset wrap need far more source bytes than this
    // run sends and are left out of it.
    while (due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #24000000;
    $display("tb: failure");
    $finish;
  end

endmodule
